// ===== rtl/lsww_pkg.sv =====
package lsww_pkg;

  localparam int MAX_WIDTH   = 255;
  localparam int OFFSET_BITS = 32;
  localparam int SPAN_BITS   = 32;
  localparam int MAP_DEPTH   = MAX_WIDTH + 1;
  localparam int MAP_BITS    = $clog2(MAP_DEPTH);
  localparam int OPQ_DEPTH   = 4;
  localparam int RESQ_DEPTH  = 4;

  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_NUL   = 8'h00;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic REG_WRAP_ENABLE = 1'b0;
  localparam logic REG_WRAP_WIDTH  = 1'b1;

  localparam logic [7:0] WRAP_WIDTH_RESET = 8'd80;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [SPAN_BITS-1:0]   span_t;
  typedef logic [MAP_BITS-1:0]    col_t;
  typedef logic [MAP_DEPTH-1:0]   map_t;

  typedef enum logic [1:0] {
    K_APPEND,
    K_NEWLINE,
    K_FLUSH
  } kind_t;

  typedef struct packed {
    logic       cr_first;
    kind_t      kind;
    logic [7:0] chr;
    logic       nul;
    offset_t    pos;
  } op_entry_t;

  typedef struct packed {
    logic       wrap_enable;
    logic [7:0] wrap_width;
  } cfg_t;

  typedef struct packed {
    logic  span_valid;
    span_t span_offset;
    span_t span_length;
    logic  ends_raw_line;
    logic  contains_nul;
    logic  last_of_run;
  } res_t;

  function automatic offset_t sat_inc(offset_t v);
    offset_t r;
    r = (&v) ? v : v + offset_t'(1);
    return r;
  endfunction

  function automatic span_t to_span(offset_t v);
    span_t r;
    if (OFFSET_BITS > SPAN_BITS && v > offset_t'({SPAN_BITS{1'b1}})) begin
      r = '1;
    end else begin
      r = span_t'(v);
    end
    return r;
  endfunction

  // {found, index of highest set bit}
  function automatic logic [MAP_BITS:0] find_last(map_t v);
    logic [MAP_BITS:0] r;
    r = '0;
    for (int i = 0; i < MAP_DEPTH; i++) begin
      if (v[i]) begin
        r = {1'b1, col_t'(i)};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/lsww_front.sv =====
module lsww_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                op,
  input  logic [7:0]          data_byte,
  output logic                full,
  input  logic                q_full,
  output logic                q_wr,
  output lsww_pkg::op_entry_t q_wdata
);

  logic              pending_cr;
  logic              nul_seen;
  lsww_pkg::offset_t byte_pos;

  logic              accept;
  logic              nul_new;
  lsww_pkg::offset_t pos_new;

  assign accept  = push && !q_full;
  assign full    = q_full;
  assign nul_new = nul_seen || (data_byte == lsww_pkg::CHR_NUL);
  assign pos_new = lsww_pkg::sat_inc(byte_pos);

  always_comb begin
    q_wdata.cr_first = pending_cr;
    q_wdata.kind     = lsww_pkg::K_APPEND;
    q_wdata.chr      = data_byte;
    q_wdata.nul      = nul_new;
    q_wdata.pos      = pos_new;
    q_wr             = accept;
    unique case (op)
      lsww_pkg::OP_END: begin
        q_wdata.kind = lsww_pkg::K_FLUSH;
        q_wdata.nul  = nul_seen;
      end
      lsww_pkg::OP_BYTE: begin
        if (data_byte == lsww_pkg::CHR_LF) begin
          q_wdata.cr_first = 1'b0;
          q_wdata.kind     = lsww_pkg::K_NEWLINE;
        end else if (data_byte == lsww_pkg::CHR_CR) begin
          // a new CR is held; only a previously held one gets appended
          q_wdata.cr_first = 1'b0;
          q_wr             = accept && pending_cr;
        end
      end
      default: begin
        q_wr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_cr <= 1'b0;
      nul_seen   <= 1'b0;
      byte_pos   <= '0;
    end else if (accept) begin
      if (op == lsww_pkg::OP_END) begin
        pending_cr <= 1'b0;
        nul_seen   <= 1'b0;
        byte_pos   <= '0;
      end else begin
        pending_cr <= (data_byte == lsww_pkg::CHR_CR);
        nul_seen   <= nul_new;
        byte_pos   <= pos_new;
      end
    end
  end

endmodule

// ===== rtl/lsww_op_queue.sv =====
module lsww_op_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  lsww_pkg::op_entry_t wdata,
  output logic                full,
  input  logic                rd,
  output lsww_pkg::op_entry_t rdata,
  output logic                empty
);

  localparam int PTR_BITS = $clog2(lsww_pkg::OPQ_DEPTH);
  localparam int CNT_BITS = $clog2(lsww_pkg::OPQ_DEPTH + 1);

  lsww_pkg::op_entry_t  slots [lsww_pkg::OPQ_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [CNT_BITS-1:0]  count;
  logic                 do_wr;
  logic                 do_rd;

  assign full  = (count == CNT_BITS'(lsww_pkg::OPQ_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(lsww_pkg::OPQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(lsww_pkg::OPQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lsww_back.sv =====
module lsww_back (
  input  logic                clk,
  input  logic                rst,
  input  lsww_pkg::cfg_t      cfg,
  input  logic                op_valid,
  input  lsww_pkg::op_entry_t op_entry,
  output logic                op_pop,
  input  logic                res_wr_ok,
  output logic                res_wr,
  output lsww_pkg::res_t      res_wdata
);

  lsww_pkg::offset_t seg_start;
  lsww_pkg::offset_t plen;
  lsww_pkg::map_t    space_map;
  logic              cr_done;
  logic              hold_valid;
  logic              hold_done;
  lsww_pkg::res_t    hold_res;

  logic                        cur_cr;
  logic                        fin;
  lsww_pkg::kind_t             kind;
  logic [7:0]                  chr;
  logic                        op_go;
  lsww_pkg::col_t              width_eff;
  lsww_pkg::map_t              map_ins;
  lsww_pkg::offset_t           plen_inc;
  logic                        cut;
  lsww_pkg::map_t              win_mask;
  logic [lsww_pkg::MAP_BITS:0] hit;
  lsww_pkg::col_t              take;
  logic [lsww_pkg::OFFSET_BITS:0] seg_sum;
  lsww_pkg::offset_t           seg_cut;

  logic              has_r;
  lsww_pkg::res_t    r;
  lsww_pkg::offset_t seg_next;
  lsww_pkg::offset_t plen_next;
  lsww_pkg::map_t    map_next;

  assign cur_cr = op_entry.cr_first && !cr_done;
  assign fin    = !cur_cr;
  assign kind   = cur_cr ? lsww_pkg::K_APPEND : op_entry.kind;
  assign chr    = cur_cr ? lsww_pkg::CHR_CR : op_entry.chr;
  assign op_go  = op_valid && (!hold_valid || res_wr_ok);
  assign op_pop = op_go && fin;

  assign width_eff = (cfg.wrap_width > lsww_pkg::MAX_WIDTH) ?
                     lsww_pkg::col_t'(lsww_pkg::MAX_WIDTH) :
                     lsww_pkg::col_t'(cfg.wrap_width);

  always_comb begin
    map_ins = space_map;
    if (plen < lsww_pkg::offset_t'(lsww_pkg::MAP_DEPTH)) begin
      map_ins[plen[lsww_pkg::MAP_BITS-1:0]] = (chr == lsww_pkg::CHR_SPACE);
    end
  end

  assign plen_inc = lsww_pkg::sat_inc(plen);
  assign cut      = cfg.wrap_enable && (width_eff != '0) &&
                    (plen_inc > lsww_pkg::offset_t'(width_eff));
  // break candidates: columns 1 .. width-1
  assign win_mask = ~(lsww_pkg::map_t'('1) << width_eff) & ~lsww_pkg::map_t'(1);
  assign hit      = lsww_pkg::find_last(map_ins & win_mask);
  assign take     = hit[lsww_pkg::MAP_BITS] ?
                    hit[lsww_pkg::MAP_BITS-1:0] + lsww_pkg::col_t'(1) : width_eff;
  assign seg_sum  = {1'b0, seg_start} +
                    {{(lsww_pkg::OFFSET_BITS + 1 - lsww_pkg::MAP_BITS){1'b0}}, take};
  assign seg_cut  = seg_sum[lsww_pkg::OFFSET_BITS] ? '1 :
                    seg_sum[lsww_pkg::OFFSET_BITS-1:0];

  always_comb begin
    has_r           = 1'b0;
    r.span_valid    = 1'b0;
    r.span_offset   = '0;
    r.span_length   = '0;
    r.ends_raw_line = 1'b0;
    r.contains_nul  = op_entry.nul;
    r.last_of_run   = 1'b0;
    seg_next        = seg_start;
    plen_next       = plen;
    map_next        = space_map;
    unique case (kind)
      lsww_pkg::K_APPEND: begin
        if (cut) begin
          has_r         = 1'b1;
          r.span_valid  = 1'b1;
          r.span_offset = lsww_pkg::to_span(seg_start);
          r.span_length = lsww_pkg::to_span(lsww_pkg::offset_t'(take));
          seg_next      = seg_cut;
          plen_next     = plen_inc - lsww_pkg::offset_t'(take);
          map_next      = map_ins >> take;
        end else begin
          plen_next = plen_inc;
          map_next  = map_ins;
        end
      end
      lsww_pkg::K_NEWLINE: begin
        has_r           = 1'b1;
        r.span_valid    = 1'b1;
        r.span_offset   = lsww_pkg::to_span(seg_start);
        r.span_length   = lsww_pkg::to_span(plen);
        r.ends_raw_line = 1'b1;
        seg_next        = op_entry.pos;
        plen_next       = '0;
        map_next        = '0;
      end
      lsww_pkg::K_FLUSH: begin
        has_r = 1'b1;
        if (plen != '0) begin
          r.span_valid    = 1'b1;
          r.span_offset   = lsww_pkg::to_span(seg_start);
          r.span_length   = lsww_pkg::to_span(plen);
          r.ends_raw_line = 1'b1;
        end
        seg_next  = '0;
        plen_next = '0;
        map_next  = '0;
      end
      default: begin
        has_r = 1'b0;
      end
    endcase
  end

  // held result leaves once it is known whether it closes its transaction
  assign res_wr = hold_valid && res_wr_ok && (hold_done || op_go);

  always_comb begin
    res_wdata             = hold_res;
    res_wdata.last_of_run = hold_done || !has_r;
  end

  always_ff @(posedge clk) begin
    if (op_go) begin
      hold_res <= r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_start  <= '0;
      plen       <= '0;
      space_map  <= '0;
      cr_done    <= 1'b0;
      hold_valid <= 1'b0;
      hold_done  <= 1'b0;
    end else begin
      if (op_go) begin
        seg_start  <= seg_next;
        plen       <= plen_next;
        space_map  <= map_next;
        cr_done    <= !fin;
        hold_valid <= has_r;
        hold_done  <= fin;
      end else if (res_wr) begin
        hold_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/lsww_res_queue.sv =====
module lsww_res_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  lsww_pkg::res_t wdata,
  output logic           wr_ok,
  input  logic           rd,
  output lsww_pkg::res_t rdata,
  output logic           empty
);

  localparam int PTR_BITS = $clog2(lsww_pkg::RESQ_DEPTH);
  localparam int CNT_BITS = $clog2(lsww_pkg::RESQ_DEPTH + 1);

  lsww_pkg::res_t       slots [lsww_pkg::RESQ_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [CNT_BITS-1:0]  count;
  logic                 full;
  logic                 do_wr;
  logic                 do_rd;

  assign full  = (count == CNT_BITS'(lsww_pkg::RESQ_DEPTH));
  assign empty = (count == '0);
  assign do_rd = rd && !empty;
  assign wr_ok = !full || do_rd;
  assign do_wr = wr && wr_ok;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(lsww_pkg::RESQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(lsww_pkg::RESQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/line_splitter_word_wrap.sv =====
// Greedy word-wrap line splitter: bytes go in through push/full, line spans
// (offset, length) come out through empty/pop, oldest first. Up to one
// transaction is taken per clock. The front classifies each byte and hands it
// through a 4-entry queue to the back, which applies one character append per
// cycle unless the held result cannot leave (a single priority encode over
// the 256-bit space map plus one shift); a byte that follows a held carriage
// return is applied after the held CR is appended. Results pass a one-entry
// hold stage that settles last_of_run, then a 4-entry output queue, both
// registered. The registers are to be written only while the block is idle:
// the user must keep to this, as the block itself does not enforce it.
// cfg_ready is always high. No clearing pass after reset.
module line_splitter_word_wrap (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic                    op,
  input  logic [7:0]              data_byte,
  output logic                    empty,
  input  logic                    pop,
  output logic                    span_valid,
  output logic [31:0]             span_offset,
  output logic [31:0]             span_length,
  output logic                    ends_raw_line,
  output logic                    contains_nul,
  output logic                    last_of_run,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [7:0]              cfg_data
);

  lsww_pkg::cfg_t      cfg;
  logic                q_full;
  logic                q_wr;
  lsww_pkg::op_entry_t q_wdata;
  logic                q_empty;
  logic                q_rd;
  lsww_pkg::op_entry_t q_rdata;
  logic                res_wr_ok;
  logic                res_wr;
  lsww_pkg::res_t      res_wdata;
  lsww_pkg::res_t      res_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wrap_enable <= 1'b0;
      cfg.wrap_width  <= lsww_pkg::WRAP_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsww_pkg::REG_WRAP_ENABLE: cfg.wrap_enable <= cfg_data[0];
        lsww_pkg::REG_WRAP_WIDTH:  cfg.wrap_width  <= cfg_data;
        default: begin
          cfg.wrap_enable <= cfg.wrap_enable;
        end
      endcase
    end
  end

  lsww_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .op        (op),
    .data_byte (data_byte),
    .full      (full),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wdata   (q_wdata)
  );

  lsww_op_queue u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  lsww_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .op_valid  (!q_empty),
    .op_entry  (q_rdata),
    .op_pop    (q_rd),
    .res_wr_ok (res_wr_ok),
    .res_wr    (res_wr),
    .res_wdata (res_wdata)
  );

  lsww_res_queue u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_wr),
    .wdata (res_wdata),
    .wr_ok (res_wr_ok),
    .rd    (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign span_valid    = res_head.span_valid;
  assign span_offset   = res_head.span_offset;
  assign span_length   = res_head.span_length;
  assign ends_raw_line = res_head.ends_raw_line;
  assign contains_nul  = res_head.contains_nul;
  assign last_of_run   = res_head.last_of_run;

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT      = 400000;
  localparam int DIR_ROWS   = 26;
  localparam int PHASES     = 9;
  localparam int RAND_ITEMS = 18;
  localparam int SETTLE     = 20;

  typedef struct packed {
    logic           op;
    logic [7:0]     data;
    logic           typed;
    lsww_pkg::res_t exp;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       op = lsww_pkg::OP_BYTE;
  logic [7:0] data_byte = 8'h00;
  logic       pop = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_index = lsww_pkg::REG_WRAP_ENABLE;
  logic [7:0] cfg_data = 8'h00;
  logic        full;
  logic        empty;
  logic        span_valid;
  logic [31:0] span_offset;
  logic [31:0] span_length;
  logic        ends_raw_line;
  logic        contains_nul;
  logic        last_of_run;
  logic        cfg_ready;

  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;
  int cycles = 0;

  int ph_en [PHASES] = '{1, 1, 1, 0, 1, 1, 1, 0, 1};
  int ph_w  [PHASES] = '{4, 255, 0, 17, 1, 2, 12, 80, 6};

  row_t dir_tab [DIR_ROWS];

  // wrap predictor state
  logic              wrap_on;
  logic [7:0]        wrap_cols;
  lsww_pkg::offset_t ch_pos;
  lsww_pkg::offset_t seg_start;
  lsww_pkg::offset_t seg_len;
  lsww_pkg::map_t    space_bits;
  logic              cr_held;
  logic              nul_flag;

  lsww_pkg::res_t step_spans[$];
  lsww_pkg::res_t pending_spans[$];

  line_splitter_word_wrap u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .data_byte    (data_byte),
    .empty        (empty),
    .pop          (pop),
    .span_valid   (span_valid),
    .span_offset  (span_offset),
    .span_length  (span_length),
    .ends_raw_line(ends_raw_line),
    .contains_nul (contains_nul),
    .last_of_run  (last_of_run),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic add_span(input logic v, input lsww_pkg::offset_t off,
                          input lsww_pkg::offset_t len, input logic ends);
    lsww_pkg::res_t r;
    r.span_valid    = v;
    r.span_offset   = v ? lsww_pkg::span_t'(off) : '0;
    r.span_length   = v ? lsww_pkg::span_t'(len) : '0;
    r.ends_raw_line = v & ends;
    r.contains_nul  = nul_flag;
    r.last_of_run   = 1'b0;
    step_spans.insert(step_spans.size(), r);
  endtask

  // append one character and make at most one cut
  task automatic append_char(input logic [7:0] c);
    int w;
    int take;
    bit found;
    logic [32:0] sum;
    if (seg_len < lsww_pkg::MAP_DEPTH)
      space_bits[seg_len[lsww_pkg::MAP_BITS-1:0]] = (c == lsww_pkg::CHR_SPACE);
    if (seg_len != '1) seg_len = seg_len + 1;
    w = wrap_cols;
    if (wrap_on && w != 0 && seg_len > w) begin
      take = w;
      found = 1'b0;
      for (int i = w - 1; i >= 1; i--) begin
        if (!found && space_bits[i]) begin
          take = i + 1;
          found = 1'b1;
        end
      end
      add_span(1'b1, seg_start, lsww_pkg::offset_t'(take), 1'b0);
      sum = {1'b0, seg_start} + 33'(take);
      seg_start = sum[32] ? '1 : sum[31:0];
      seg_len = seg_len - lsww_pkg::offset_t'(take);
      space_bits = space_bits >> take;
    end
  endtask

  task automatic predict_spans(input logic o, input logic [7:0] c);
    step_spans.delete();
    if (o == lsww_pkg::OP_END) begin
      if (cr_held) begin
        cr_held = 1'b0;
        append_char(lsww_pkg::CHR_CR);
      end
      if (seg_len != 0) add_span(1'b1, seg_start, seg_len, 1'b1);
      if (step_spans.size() == 0) add_span(1'b0, '0, '0, 1'b0);
      ch_pos = '0;
      seg_start = '0;
      seg_len = '0;
      space_bits = '0;
      nul_flag = 1'b0;
    end else begin
      if (c == lsww_pkg::CHR_NUL) nul_flag = 1'b1;
      if (ch_pos != '1) ch_pos = ch_pos + 1;
      if (c == lsww_pkg::CHR_LF) begin
        cr_held = 1'b0;
        add_span(1'b1, seg_start, seg_len, 1'b1);
        seg_start = ch_pos;
        seg_len = '0;
        space_bits = '0;
      end else begin
        if (cr_held) begin
          cr_held = 1'b0;
          append_char(lsww_pkg::CHR_CR);
        end
        if (c == lsww_pkg::CHR_CR) cr_held = 1'b1;
        else append_char(c);
      end
    end
    if (step_spans.size() != 0)
      step_spans[step_spans.size() - 1].last_of_run = 1'b1;
  endtask

  task automatic send_item(input logic o, input logic [7:0] d, input logic typed,
                           input lsww_pkg::res_t e);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    op <= o;
    data_byte <= d;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_spans(o, d);
    if (typed) pending_spans.insert(pending_spans.size(), e);
    else while (step_spans.size() != 0)
      pending_spans.insert(pending_spans.size(), step_spans.pop_front());
  endtask

  task automatic drain_spans();
    @(negedge clk);
    push <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == lsww_pkg::REG_WRAP_ENABLE) wrap_on = d[0];
    else wrap_cols = d;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'h61 + 8'($urandom_range(25));
    else if (r < 95) return lsww_pkg::CHR_SPACE;
    else return 8'($urandom);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk) pop <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin : rx
    lsww_pkg::res_t want;
    if (!rst && pop && empty === 1'b0) begin
      if (pending_spans.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected span transaction, expected none, actual %0h/%0h",
                 $time, span_offset, span_length);
      end else begin
        want = pending_spans.pop_front();
        check_field("span_valid", 32'(want.span_valid), 32'(span_valid));
        check_field("span_offset", want.span_offset, span_offset);
        check_field("span_length", want.span_length, span_length);
        check_field("ends_raw_line", 32'(want.ends_raw_line), 32'(ends_raw_line));
        check_field("contains_nul", 32'(want.contains_nul), 32'(contains_nul));
        check_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run));
      end
    end
  end

  initial begin : main
    int sent;
    int len;
    int roll;
    int maxlen;
    bit drained;

    wrap_on = 1'b0;
    wrap_cols = lsww_pkg::WRAP_WIDTH_RESET;
    ch_pos = '0;
    seg_start = '0;
    seg_len = '0;
    space_bits = '0;
    cr_held = 1'b0;
    nul_flag = 1'b0;

    // width 4, wrap on
    dir_tab[0]  = {lsww_pkg::OP_END,  lsww_pkg::CHR_NUL,   1'b1,
                   {1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1}};
    dir_tab[1]  = {lsww_pkg::OP_BYTE, lsww_pkg::CHR_LF,    1'b1,
                   {1'b1, 32'd0, 32'd0, 1'b1, 1'b0, 1'b1}};
    dir_tab[2]  = {lsww_pkg::OP_BYTE, 8'h61,               1'b0, 68'd0};
    dir_tab[3]  = {lsww_pkg::OP_BYTE, lsww_pkg::CHR_CR,    1'b0, 68'd0};
    dir_tab[4]  = {lsww_pkg::OP_BYTE, lsww_pkg::CHR_LF,    1'b1,
                   {1'b1, 32'd1, 32'd1, 1'b1, 1'b0, 1'b1}};
    dir_tab[5]  = {lsww_pkg::OP_BYTE, lsww_pkg::CHR_SPACE, 1'b0, 68'd0};
    dir_tab[6]  = {lsww_pkg::OP_BYTE, 8'h61,               1'b0, 68'd0};
    dir_tab[7]  = {lsww_pkg::OP_BYTE, 8'h62,               1'b0, 68'd0};
    dir_tab[8]  = {lsww_pkg::OP_BYTE, 8'h63,               1'b0, 68'd0};
    dir_tab[9]  = {lsww_pkg::OP_BYTE, 8'h64,               1'b0, 68'd0};
    dir_tab[10] = {lsww_pkg::OP_BYTE, lsww_pkg::CHR_SPACE, 1'b0, 68'd0};
    dir_tab[11] = {lsww_pkg::OP_BYTE, 8'h65,               1'b0, 68'd0};
    dir_tab[12] = {lsww_pkg::OP_BYTE, 8'h66,               1'b0, 68'd0};
    dir_tab[13] = {lsww_pkg::OP_BYTE, 8'h67,               1'b0, 68'd0};
    dir_tab[14] = {lsww_pkg::OP_BYTE, lsww_pkg::CHR_CR,    1'b0, 68'd0};
    dir_tab[15] = {lsww_pkg::OP_BYTE, 8'h68,               1'b0, 68'd0};
    dir_tab[16] = {lsww_pkg::OP_BYTE, lsww_pkg::CHR_NUL,   1'b0, 68'd0};
    dir_tab[17] = {lsww_pkg::OP_BYTE, 8'hFF,               1'b0, 68'd0};
    dir_tab[18] = {lsww_pkg::OP_BYTE, 8'h69,               1'b0, 68'd0};
    dir_tab[19] = {lsww_pkg::OP_BYTE, lsww_pkg::CHR_CR,    1'b0, 68'd0};
    dir_tab[20] = {lsww_pkg::OP_END,  8'hFF,               1'b0, 68'd0};
    dir_tab[21] = {lsww_pkg::OP_END,  lsww_pkg::CHR_LF,    1'b1,
                   {1'b0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1}};
    dir_tab[22] = {lsww_pkg::OP_BYTE, 8'h7A,               1'b0, 68'd0};
    dir_tab[23] = {lsww_pkg::OP_BYTE, lsww_pkg::CHR_CR,    1'b0, 68'd0};
    dir_tab[24] = {lsww_pkg::OP_BYTE, lsww_pkg::CHR_CR,    1'b0, 68'd0};
    dir_tab[25] = {lsww_pkg::OP_BYTE, lsww_pkg::CHR_LF,    1'b1,
                   {1'b1, 32'd0, 32'd2, 1'b1, 1'b0, 1'b1}};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      send_idle = (p < 3) ? 9 : (p < 6) ? 63 : 0;
      recv_idle = (p < 3) ? 63 : (p < 6) ? 9 : 0;
      write_reg(lsww_pkg::REG_WRAP_ENABLE, {7'($urandom), 1'(ph_en[p])});
      write_reg(lsww_pkg::REG_WRAP_WIDTH, 8'(ph_w[p]));

      if (p == 0) begin
        for (int i = 0; i < DIR_ROWS; i++)
          send_item(dir_tab[i].op, dir_tab[i].data, dir_tab[i].typed, dir_tab[i].exp);
      end else begin
        sent = 0;
        drained = 1'b0;
        if (!wrap_on || wrap_cols == 0) maxlen = 20;
        else maxlen = (2 * wrap_cols + 3 > 30) ? 30 : 2 * wrap_cols + 3;
        // one line past the full map depth
        if (wrap_on && wrap_cols > 200) begin
          for (int i = 0; i < 260; i++)
            send_item(lsww_pkg::OP_BYTE, word_char(), 1'b0, '0);
          send_item(lsww_pkg::OP_BYTE, lsww_pkg::CHR_LF, 1'b0, '0);
          sent = 261;
        end
        while (sent < RAND_ITEMS + 261 * (wrap_cols > 200 && wrap_on)) begin
          if (!drained && sent >= RAND_ITEMS / 2) begin
            drain_spans();
            drained = 1'b1;
          end
          roll = $urandom_range(99);
          if (roll < 85) begin
            len = $urandom_range(maxlen);
            for (int i = 0; i < len; i++)
              send_item(lsww_pkg::OP_BYTE, word_char(), 1'b0, '0);
            sent += len;
            roll = $urandom_range(99);
            if (roll < 60) begin
              send_item(lsww_pkg::OP_BYTE, lsww_pkg::CHR_LF, 1'b0, '0);
              sent++;
            end else if (roll < 75) begin
              send_item(lsww_pkg::OP_BYTE, lsww_pkg::CHR_CR, 1'b0, '0);
              send_item(lsww_pkg::OP_BYTE, lsww_pkg::CHR_LF, 1'b0, '0);
              sent += 2;
            end else if (roll < 85) begin
              send_item(lsww_pkg::OP_END, 8'($urandom), 1'b0, '0);
              sent++;
            end
          end else if (roll < 95) begin
            send_item(lsww_pkg::OP_BYTE, 8'($urandom), 1'b0, '0);
            sent++;
          end else begin
            send_item(lsww_pkg::OP_END, 8'($urandom), 1'b0, '0);
            sent++;
          end
        end
      end

      drain_spans();
      repeat (SETTLE) @(posedge clk);
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
